// ===== rtl/ims_pkg.sv =====
// ----------------------------------------------------------------------------
// ims_pkg
// Types and constants shared by the inline markup stripper modules.
// ----------------------------------------------------------------------------
package ims_pkg;

	localparam int MAX_LEN = 4096;

	localparam int POS_W  = 12;
	localparam int CNT_W  = 13;
	localparam int CHAR_W = 16;

	localparam logic [CNT_W-1:0] RC_SAT =
		(MAX_LEN < 8191) ? CNT_W'(MAX_LEN) : CNT_W'(8191);

	localparam logic [CHAR_W-1:0] CH_BAR     = 16'h007C;
	localparam logic [CHAR_W-1:0] CH_COLOUR  = 16'h0063;
	localparam logic [CHAR_W-1:0] CH_RESTORE = 16'h0072;
	localparam logic [CHAR_W-1:0] CH_LINK_ON = 16'h0048;
	localparam logic [CHAR_W-1:0] CH_LINK_OFF = 16'h0068;
	localparam logic [CHAR_W-1:0] CH_EMOJI_ON = 16'h0045;
	localparam logic [CHAR_W-1:0] CH_EMOJI_OFF = 16'h0065;

	localparam logic [3:0]       COLOUR_SKIP = 4'd8;
	localparam logic [CNT_W-1:0] COLOUR_MIN_LEFT = 13'd9;

	typedef enum logic {
		CFG_EMOJI_ENABLE = 1'b0,
		CFG_QUERY_POS    = 1'b1
	} cfg_index_t;

	typedef enum logic {
		KIND_VISIBLE = 1'b0,
		KIND_SUMMARY = 1'b1
	} kind_t;

	// Results caused by one character: a bar, a character, a summary.
	typedef struct packed {
		logic [2:0]        mask;
		logic [POS_W-1:0]  a_render;
		logic [POS_W-1:0]  a_caret;
		logic [CHAR_W-1:0] b_char;
		logic [POS_W-1:0]  b_render;
		logic [POS_W-1:0]  b_caret;
		logic [CNT_W-1:0]  sum_count;
		logic [POS_W-1:0]  sum_answer;
	} ims_bundle_t;

endpackage

// ===== rtl/ims_step.sv =====
// ----------------------------------------------------------------------------
// ims_step
// Input register and markup parser; builds the result bundle of one character.
// ----------------------------------------------------------------------------
module ims_step
	import ims_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [CHAR_W-1:0] char_code,
	input  logic [CNT_W-1:0]  chars_left,
	input  logic              emoji_enable,
	input  logic [CNT_W-1:0]  query_render_pos,
	input  logic              slot_free,
	output logic              bundle_load,
	output ims_bundle_t       bundle
);

	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic [CNT_W-1:0]  left_s1;

	logic              bar_pending_q;
	logic [POS_W-1:0]  bar_position_q;
	logic [3:0]        skip_left_q;
	logic              hidden_span_q;
	logic              colour_active_q;
	logic [POS_W-1:0]  caret_hold_q;
	logic [POS_W-1:0]  source_position_q;
	logic [CNT_W-1:0]  render_count_q;
	logic              query_found_q;
	logic [POS_W-1:0]  query_hold_q;

	logic              bar_pending_n;
	logic [POS_W-1:0]  bar_position_n;
	logic [3:0]        skip_left_n;
	logic              hidden_span_n;
	logic              colour_active_n;
	logic [POS_W-1:0]  caret_hold_n;
	logic [CNT_W-1:0]  render_count_n;
	logic              query_found_n;
	logic [POS_W-1:0]  query_hold_n;

	logic              vis_a;
	logic              vis_b;
	logic [CHAR_W-1:0] b_char;
	logic [POS_W-1:0]  b_pos;
	logic              last;
	logic              in_take;

	assign bundle_load = valid_s1 && slot_free;
	assign in_stall    = valid_s1 && !slot_free;
	assign in_take     = in_valid && !in_stall;
	assign last        = (left_s1 <= 13'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (bundle_load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			char_s1 <= char_code;
			left_s1 <= chars_left;
		end
	end

	always_comb begin
		bar_pending_n   = bar_pending_q;
		bar_position_n  = bar_position_q;
		skip_left_n     = skip_left_q;
		hidden_span_n   = hidden_span_q;
		colour_active_n = colour_active_q;
		caret_hold_n    = caret_hold_q;
		render_count_n  = render_count_q;
		query_found_n   = query_found_q;
		query_hold_n    = query_hold_q;
		vis_a  = 1'b0;
		vis_b  = 1'b0;
		b_char = char_s1;
		b_pos  = source_position_q;
		bundle = '0;

		priority if (skip_left_q != 4'd0) begin
			skip_left_n = skip_left_q - 4'd1;
		end else if (bar_pending_q) begin
			bar_pending_n = 1'b0;
			priority if (char_s1 == CH_BAR) begin
				vis_b = 1'b1;
				b_pos = bar_position_q;
			end else if (char_s1 == CH_COLOUR && left_s1 >= COLOUR_MIN_LEFT) begin
				colour_active_n = 1'b1;
				caret_hold_n    = bar_position_q;
				skip_left_n     = COLOUR_SKIP;
			end else if (char_s1 == CH_RESTORE) begin
				colour_active_n = 1'b0;
			end else if (char_s1 == CH_LINK_ON) begin
				hidden_span_n = 1'b1;
			end else if (char_s1 == CH_LINK_OFF) begin
				hidden_span_n = 1'b0;
			end else if (emoji_enable && char_s1 == CH_EMOJI_ON) begin
				hidden_span_n = 1'b1;
			end else if (emoji_enable && char_s1 == CH_EMOJI_OFF) begin
				hidden_span_n = 1'b0;
			end else begin
				vis_a = 1'b1;
				vis_b = 1'b1;
			end
		end else if (char_s1 == CH_BAR && left_s1 >= 13'd2) begin
			bar_pending_n  = 1'b1;
			bar_position_n = source_position_q;
		end else begin
			vis_b = 1'b1;
		end

		// plain bar ahead of the character
		if (vis_a && !hidden_span_q) begin
			if (!colour_active_q) begin
				caret_hold_n = bar_position_q;
			end
			if (!query_found_n && query_render_pos <= render_count_n) begin
				query_found_n = 1'b1;
				query_hold_n  = caret_hold_n;
			end
			bundle.mask[0]  = 1'b1;
			bundle.a_render = render_count_n[POS_W-1:0];
			bundle.a_caret  = caret_hold_n;
			if (render_count_n < RC_SAT) begin
				render_count_n = render_count_n + 13'd1;
			end
		end

		if (vis_b && !hidden_span_q) begin
			if (!colour_active_q) begin
				caret_hold_n = b_pos;
			end
			if (!query_found_n && query_render_pos <= render_count_n) begin
				query_found_n = 1'b1;
				query_hold_n  = caret_hold_n;
			end
			bundle.mask[1]  = 1'b1;
			bundle.b_char   = b_char;
			bundle.b_render = render_count_n[POS_W-1:0];
			bundle.b_caret  = caret_hold_n;
			if (render_count_n < RC_SAT) begin
				render_count_n = render_count_n + 13'd1;
			end
		end

		if (last) begin
			bundle.mask[2]    = 1'b1;
			bundle.sum_count  = render_count_n;
			bundle.sum_answer = query_found_n ? query_hold_n : caret_hold_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bar_pending_q     <= 1'b0;
			bar_position_q    <= '0;
			skip_left_q       <= '0;
			hidden_span_q     <= 1'b0;
			colour_active_q   <= 1'b0;
			caret_hold_q      <= '0;
			source_position_q <= '0;
			render_count_q    <= '0;
			query_found_q     <= 1'b0;
			query_hold_q      <= '0;
		end else if (bundle_load) begin
			if (last) begin
				bar_pending_q     <= 1'b0;
				bar_position_q    <= '0;
				skip_left_q       <= '0;
				hidden_span_q     <= 1'b0;
				colour_active_q   <= 1'b0;
				caret_hold_q      <= '0;
				source_position_q <= '0;
				render_count_q    <= '0;
				query_found_q     <= 1'b0;
				query_hold_q      <= '0;
			end else begin
				bar_pending_q     <= bar_pending_n;
				bar_position_q    <= bar_position_n;
				skip_left_q       <= skip_left_n;
				hidden_span_q     <= hidden_span_n;
				colour_active_q   <= colour_active_n;
				caret_hold_q      <= caret_hold_n;
				source_position_q <= source_position_q + 12'd1;
				render_count_q    <= render_count_n;
				query_found_q     <= query_found_n;
				query_hold_q      <= query_hold_n;
			end
		end
	end

endmodule

// ===== rtl/ims_outq.sv =====
// ----------------------------------------------------------------------------
// ims_outq
// Result register; hands out the bundle of one character one result at a time.
// ----------------------------------------------------------------------------
module ims_outq
	import ims_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               bundle_load,
	input  ims_bundle_t        bundle,
	output logic               slot_free,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               kind,
	output logic [CHAR_W-1:0]  out_char,
	output logic [POS_W-1:0]   render_index,
	output logic [POS_W-1:0]   caret_index,
	output logic [CNT_W-1:0]   visible_count,
	output logic [POS_W-1:0]   query_answer,
	output logic               end_flag
);

	logic [2:0]  mask_s2;
	ims_bundle_t data_s2;
	logic [2:0]  first_bit;
	logic        out_take;

	assign first_bit = mask_s2 & (~mask_s2 + 3'd1);
	assign out_valid = |mask_s2;
	assign out_take  = out_valid && !out_stall;
	assign slot_free = !out_valid || (out_take && (mask_s2 == first_bit));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_s2 <= '0;
		end else if (bundle_load) begin
			mask_s2 <= bundle.mask;
		end else if (out_take) begin
			mask_s2 <= mask_s2 & ~first_bit;
		end
	end

	always_ff @(posedge clk) begin
		if (bundle_load) begin
			data_s2 <= bundle;
		end
	end

	always_comb begin
		kind          = KIND_VISIBLE;
		out_char      = '0;
		render_index  = '0;
		caret_index   = '0;
		visible_count = '0;
		query_answer  = '0;
		end_flag      = 1'b0;
		priority if (mask_s2[0]) begin
			out_char     = CH_BAR;
			render_index = data_s2.a_render;
			caret_index  = data_s2.a_caret;
		end else if (mask_s2[1]) begin
			out_char     = data_s2.b_char;
			render_index = data_s2.b_render;
			caret_index  = data_s2.b_caret;
		end else begin
			kind          = KIND_SUMMARY;
			visible_count = data_s2.sum_count;
			query_answer  = data_s2.sum_answer;
			end_flag      = 1'b1;
		end
	end

endmodule

// ===== rtl/inline_markup_stripper.sv =====
// ----------------------------------------------------------------------------
// inline_markup_stripper
// Strips bar-escape markup from a character stream and maps carets.
// ----------------------------------------------------------------------------
// A character's first result is shown once it has passed the input and result registers.
// Throughput: one character per cycle while each yields at most one result and
//   out_stall is low; a character with two or three results holds the input
//   until the single result port has handed all of them out.
// Reset: clears the pipeline, string state and both configuration registers.
module inline_markup_stripper
	import ims_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [CNT_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [CHAR_W-1:0] char_code,
	input  logic [CNT_W-1:0]  chars_left,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              kind,
	output logic [CHAR_W-1:0] out_char,
	output logic [POS_W-1:0]  render_index,
	output logic [POS_W-1:0]  caret_index,
	output logic [CNT_W-1:0]  visible_count,
	output logic [POS_W-1:0]  query_answer,
	output logic              end_flag
);

	logic             emoji_enable_q;
	logic [CNT_W-1:0] query_render_pos_q;
	logic             slot_free;
	logic             bundle_load;
	ims_bundle_t      bundle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emoji_enable_q     <= 1'b0;
			query_render_pos_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_EMOJI_ENABLE: emoji_enable_q     <= cfg_data[0];
				CFG_QUERY_POS:    query_render_pos_q <= cfg_data;
			endcase
		end
	end

	ims_step u_step (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.char_code        (char_code),
		.chars_left       (chars_left),
		.emoji_enable     (emoji_enable_q),
		.query_render_pos (query_render_pos_q),
		.slot_free        (slot_free),
		.bundle_load      (bundle_load),
		.bundle           (bundle)
	);

	ims_outq u_outq (
		.clk           (clk),
		.arst_n        (arst_n),
		.bundle_load   (bundle_load),
		.bundle        (bundle),
		.slot_free     (slot_free),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.out_char      (out_char),
		.render_index  (render_index),
		.caret_index   (caret_index),
		.visible_count (visible_count),
		.query_answer  (query_answer),
		.end_flag      (end_flag)
	);

endmodule

// ===== rtl/ims_checker.sv =====
// ----------------------------------------------------------------------------
// ims_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module ims_checker
	import ims_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_stall,
	input logic              kind,
	input logic [CHAR_W-1:0] out_char,
	input logic [POS_W-1:0]  render_index,
	input logic [POS_W-1:0]  caret_index,
	input logic [CNT_W-1:0]  visible_count,
	input logic [POS_W-1:0]  query_answer,
	input logic              end_flag
);

	a_end_on_summary: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (end_flag == kind))
		else $error("end_flag does not match summary kind");

	a_visible_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !kind) |-> (visible_count == '0 && query_answer == '0))
		else $error("summary fields set on visible transaction");

	a_summary_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind) |-> (out_char == '0 && render_index == '0 && caret_index == '0))
		else $error("character fields set on summary transaction");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(kind) && $stable(out_char)))
		else $error("stalled result changed");

endmodule

bind inline_markup_stripper ims_checker u_ims_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.kind          (kind),
	.out_char      (out_char),
	.render_index  (render_index),
	.caret_index   (caret_index),
	.visible_count (visible_count),
	.query_answer  (query_answer),
	.end_flag      (end_flag)
);
